@@ hw/rtl/osm_pkg.sv @@
// shared types and codes for the order statistic multiset
package osm_pkg;

    localparam int VAL_W = 31;

    typedef logic [VAL_W-1:0] t_value;

    // operation codes carried by an input beat
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_RANK   = 2'd2,
        KIND_SELECT = 2'd3
    } t_kind;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // update strobes broadcast along the row of cells
    typedef struct packed {
        logic   ins;
        logic   del;
        t_value value;
    } t_cell_cmd;

endpackage

@@ hw/rtl/osm_cell.sv @@
// one storage cell of the sorted row: holds an element and shifts it to a neighbour
module osm_cell #(
    parameter int IDX = 0,
    parameter int IW  = 9
) (
    input  logic               i_clk,
    input  osm_pkg::t_cell_cmd i_cmd,
    input  logic [IW-1:0]      i_count,
    input  logic [IW-1:0]      i_pos,
    input  osm_pkg::t_value    i_left_value,
    input  logic               i_left_le,
    input  osm_pkg::t_value    i_right_value,
    output osm_pkg::t_value    o_value,
    output logic               o_le,
    output logic               o_lt,
    output logic               o_hit
);
    import osm_pkg::*;

    t_value r_value;
    logic   r_le;
    logic   r_lt;
    logic   occ;
    logic   at_or_after;

    // position of this cell against the fill level and the requested position
    assign occ         = IW'(IDX) < i_count;
    assign o_hit       = IW'(IDX) == i_pos;
    assign at_or_after = IW'(IDX) >= i_pos;

    // compare flags, registered ahead of the shift
    always_ff @(posedge i_clk) begin
        r_le <= occ && (r_value <= i_cmd.value);
        r_lt <= occ && (r_value < i_cmd.value);
    end

    // insert opens a gap after the last element not greater; delete closes one
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (!r_le) begin
                r_value <= i_left_le ? i_cmd.value : i_left_value;
            end
        end else if (i_cmd.del && at_or_after) begin
            r_value <= i_right_value;
        end
    end

    assign o_value = r_value;
    assign o_le    = r_le;
    assign o_lt    = r_lt;

endmodule

@@ hw/rtl/order_statistic_multiset_core.sv @@
// top level of the order statistic multiset: control, row of cells, result register
// each operation is accepted in idle, then passes the compare and update states; the result
// is registered on commit, and no new operation is accepted until then; a result not yet
// taken holds the update state and so blocks further intake
// reset: synchronous active low, empties the store and clears all handshakes
// cell contents are not cleared; cells at or above the fill count are ignored
module order_statistic_multiset_core #(
    parameter int CAPACITY = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_kind,
    input  osm_pkg::t_value i_value,
    input  logic [7:0]      i_position,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output osm_pkg::t_value o_answer,
    output logic [1:0]      o_status,
    output logic [8:0]      o_count
);
    import osm_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > 8) ? CW : 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state         r_state;
    t_kind          r_kind;
    t_value         r_value;
    logic [IW-1:0]  r_pos;
    logic [CW-1:0]  r_count;
    t_value         r_pick;
    logic           r_out_valid;
    t_value         r_answer;
    logic [1:0]     r_status;
    logic [8:0]     r_out_count;

    t_value          cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_le;
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_hit;
    logic [CAPACITY:0]   lt_ext;

    t_cell_cmd      cmd;
    logic [IW-1:0]  count_x;
    logic           out_free;
    logic           commit;
    logic           full;
    logic           in_range;
    t_value         pick;
    logic [CW-1:0]  rank;
    t_value         n_answer;
    logic [1:0]     n_status;
    logic [CW-1:0]  n_count;

    // handshake and commit conditions
    assign count_x    = IW'(r_count);
    assign out_free   = !r_out_valid || i_out_ready;
    assign commit     = (r_state == S_UPD) && out_free;
    assign full       = r_count == CW'(CAPACITY);
    assign in_range   = r_pos < count_x;
    assign o_in_ready = r_state == S_IDLE;

    // strobes for the row
    assign cmd.ins   = commit && (r_kind == KIND_INSERT) && !full;
    assign cmd.del   = commit && (r_kind == KIND_DELETE) && in_range;
    assign cmd.value = r_value;

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_value left_v;
        t_value right_v;
        logic   left_le;

        if (g == 0) begin : g_first
            assign left_v  = r_value;
            assign left_le = 1'b1;
        end else begin : g_inner
            assign left_v  = cell_value[g-1];
            assign left_le = cell_le[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_v = cell_value[g];
        end else begin : g_body
            assign right_v = cell_value[g+1];
        end

        osm_cell #(
            .IDX (g),
            .IW  (IW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_count       (count_x),
            .i_pos         (r_pos),
            .i_left_value  (left_v),
            .i_left_le     (left_le),
            .i_right_value (right_v),
            .o_value       (cell_value[g]),
            .o_le          (cell_le[g]),
            .o_lt          (cell_lt[g]),
            .o_hit         (cell_hit[g])
        );
    end

    // element at the requested position
    always_comb begin
        pick = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_hit[i]) begin
                pick = pick | cell_value[i];
            end
        end
    end

    // the less-than flags form a prefix, so the rank is where that prefix ends
    assign lt_ext = {1'b0, cell_lt};
    always_comb begin
        rank = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (lt_ext[i] && !lt_ext[i+1]) begin
                rank = rank | CW'(i + 1);
            end
        end
    end

    // result of the operation in hand
    always_comb begin
        n_answer = '0;
        n_status = ST_DONE;
        n_count  = r_count;
        unique case (r_kind)
            KIND_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            KIND_DELETE: begin
                if (in_range) begin
                    n_answer = r_pick;
                    n_count  = r_count - CW'(1);
                end else begin
                    n_status = ST_RANGE;
                end
            end
            KIND_RANK: begin
                n_answer = VAL_W'(rank);
            end
            KIND_SELECT: begin
                if (in_range) begin
                    n_answer = r_pick;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // sequencer, fill count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !commit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind  <= t_kind'(i_kind);
                        r_value <= i_value;
                        r_pos   <= IW'(i_position);
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_pick  <= pick;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_answer    <= n_answer;
                        r_status    <= n_status;
                        r_out_count <= 9'(n_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_answer;
    assign o_status    = r_status;
    assign o_count     = r_out_count;

    // fill level never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // a successful insert grows the store by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the store");

    // a successful delete shrinks the store by one
    a_delete_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.del |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the store");

    // the store only changes when a result is committed
    a_count_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |=> (r_count == $past(r_count)))
        else $error("fill count changed without a commit");

endmodule

@@ test/order_statistic_multiset_core_tb.sv @@
// testbench for the order statistic multiset: random and directed operations
module order_statistic_multiset_core_tb;

    import osm_pkg::*;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 200000;

    // one operation waiting to be sent, with an optional hold until all answers are in
    typedef struct {
        t_kind      kind;
        t_value     value;
        logic [7:0] position;
        bit         drain;
    } t_op;

    // one answer beat as the block should give it
    typedef struct {
        t_value     answer;
        logic [1:0] status;
        logic [8:0] count;
    } t_answer;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] kind_drv = KIND_INSERT;
    t_value     value_drv = '0;
    logic [7:0] position_drv = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_value     answer_mon;
    logic [1:0] status_mon;
    logic [8:0] count_mon;

    t_op     ops_to_send[$];
    t_answer answers_due[$];

    // predictor state: sorted copy of the multiset
    t_value  held_values[DEPTH];
    int      held_n = 0;

    int      errors = 0;
    int      cycles = 0;
    int      gap_left = 0;
    int      stall_left = 0;
    int      sent_n = 0;
    int      taken_n = 0;
    int      fill = 0;

    order_statistic_multiset_core #(
        .CAPACITY(DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_kind     (kind_drv),
        .i_value    (value_drv),
        .i_position (position_drv),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_answer   (answer_mon),
        .o_status   (status_mon),
        .o_count    (count_mon)
    );

    // clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // apply one operation to the sorted copy and give the answer it should produce
    function automatic t_answer multiset_step(t_op op);
        t_answer r;
        int      at;
        r.answer = '0;
        r.status = ST_DONE;
        case (op.kind)
            KIND_INSERT: begin
                if (held_n >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    at = 0;
                    for (int i = 0; i < held_n; i++)
                        if (held_values[i] <= op.value) at++;
                    for (int i = held_n; i > at; i--)
                        held_values[i] = held_values[i-1];
                    held_values[at] = op.value;
                    held_n++;
                end
            end
            KIND_RANK: begin
                at = 0;
                for (int i = 0; i < held_n; i++)
                    if (held_values[i] < op.value) at++;
                r.answer = t_value'(at);
            end
            default: begin
                if (int'(op.position) >= held_n) begin
                    r.status = ST_RANGE;
                end else begin
                    r.answer = held_values[op.position];
                    if (op.kind == KIND_DELETE) begin
                        for (int i = int'(op.position); i + 1 < held_n; i++)
                            held_values[i] = held_values[i+1];
                        held_n--;
                    end
                end
            end
        endcase
        r.count = 9'(held_n);
        return r;
    endfunction

    // queue one operation and track the fill level it leaves
    function automatic void queue_op(t_kind kind, t_value value, logic [7:0] position,
                                     bit drain);
        t_op op;
        op.kind     = kind;
        op.value    = value;
        op.position = position;
        op.drain    = drain;
        ops_to_send.push_back(op);
        if (kind == KIND_INSERT && fill < DEPTH) fill++;
        if (kind == KIND_DELETE && int'(position) < fill) fill--;
    endfunction

    // values: many small ones for duplicates, some extremes, the rest anywhere
    function automatic t_value draw_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return t_value'($urandom_range(0, 15));
        if (r < 35) return '0;
        if (r < 40) return '1;
        return t_value'($urandom());
    endfunction

    // positions: inside the stored range when asked for and the store is not empty, otherwise anywhere
    function automatic logic [7:0] draw_position(bit good);
        if (good && fill > 0) return 8'($urandom_range(0, fill - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // input side: one beat per pending operation, random gaps between beats
    always @(posedge clk) begin
        t_op op;
        bit  calm;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left = $urandom_range(0, 4);
        end else begin
            calm = ((sent_n / 64) % 4) == 3;
            if (in_valid && in_ready) sent_n++;
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (ops_to_send.size() > 0 &&
                             (!ops_to_send[0].drain ||
                              (!in_valid && answers_due.size() == 0))) begin
                    op = ops_to_send.pop_front();
                    in_valid     <= 1'b1;
                    kind_drv     <= op.kind;
                    value_drv    <= op.value;
                    position_drv <= op.position;
                    gap_left = calm ? 0 : $urandom_range(0, 4);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: random stall before each answer beat
    always @(posedge clk) begin
        bit calm;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            calm = ((taken_n / 64) % 4) == 1;
            if (out_valid && out_ready) begin
                taken_n++;
                stall_left = calm ? 0 : $urandom_range(0, 4);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_ready <= (stall_left == 0);
        end
    end

    // check answer beats against the oldest prediction, then predict accepted inputs
    always @(posedge clk) begin
        t_answer want;
        t_op     op;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected answer beat expected none actual %0h/%0h/%0h",
                             $time, answer_mon, status_mon, count_mon);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (answer_mon !== want.answer) begin
                        $display("%0t: answer mismatch expected %0h actual %0h",
                                 $time, want.answer, answer_mon);
                        errors++;
                    end
                    if (status_mon !== want.status) begin
                        $display("%0t: status mismatch expected %0h actual %0h",
                                 $time, want.status, status_mon);
                        errors++;
                    end
                    if (count_mon !== want.count) begin
                        $display("%0t: count mismatch expected %0d actual %0d",
                                 $time, want.count, count_mon);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                op.kind     = t_kind'(kind_drv);
                op.value    = value_drv;
                op.position = position_drv;
                op.drain    = 1'b0;
                answers_due.push_back(multiset_step(op));
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("order_statistic_multiset_core verification failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int r;
        bit start;

        // directed: empty store, extremes, duplicates, out of range positions
        queue_op(KIND_SELECT, draw_value(), 8'd0, 1'b0);
        queue_op(KIND_DELETE, draw_value(), 8'd255, 1'b0);
        queue_op(KIND_RANK, '1, draw_position(1'b0), 1'b0);
        queue_op(KIND_INSERT, '1, draw_position(1'b0), 1'b0);
        queue_op(KIND_INSERT, '0, draw_position(1'b0), 1'b0);
        queue_op(KIND_INSERT, t_value'(5), draw_position(1'b0), 1'b0);
        queue_op(KIND_INSERT, t_value'(5), draw_position(1'b0), 1'b0);
        queue_op(KIND_INSERT, t_value'(5), draw_position(1'b0), 1'b0);
        queue_op(KIND_RANK, t_value'(5), draw_position(1'b0), 1'b0);
        queue_op(KIND_RANK, t_value'(6), draw_position(1'b0), 1'b0);
        queue_op(KIND_RANK, '1, draw_position(1'b0), 1'b0);
        queue_op(KIND_RANK, '0, draw_position(1'b0), 1'b0);
        queue_op(KIND_SELECT, draw_value(), 8'd0, 1'b0);
        queue_op(KIND_SELECT, draw_value(), 8'd4, 1'b0);
        queue_op(KIND_SELECT, draw_value(), 8'd5, 1'b0);
        queue_op(KIND_SELECT, draw_value(), 8'd255, 1'b0);
        queue_op(KIND_DELETE, draw_value(), 8'd2, 1'b0);
        queue_op(KIND_DELETE, draw_value(), 8'd3, 1'b0);
        queue_op(KIND_DELETE, draw_value(), 8'd3, 1'b0);
        queue_op(KIND_SELECT, draw_value(), 8'd1, 1'b0);
        queue_op(KIND_DELETE, draw_value(), 8'd0, 1'b0);
        queue_op(KIND_DELETE, draw_value(), 8'd0, 1'b0);
        queue_op(KIND_DELETE, draw_value(), 8'd0, 1'b0);
        queue_op(KIND_RANK, t_value'(1), draw_position(1'b0), 1'b0);

        // fill the store to capacity, held until the directed answers are in
        start = 1'b1;
        while (fill < DEPTH) begin
            r = $urandom_range(0, 99);
            if (r < 86)
                queue_op(KIND_INSERT, draw_value(), draw_position(1'b0), start);
            else if (r < 93)
                queue_op(KIND_RANK, draw_value(), draw_position(1'b0), start);
            else if (r < 97)
                queue_op(KIND_SELECT, draw_value(), draw_position(1'b1), start);
            else
                queue_op(KIND_DELETE, draw_value(), draw_position(1'b1), start);
            start = 1'b0;
        end

        // full store: dropped inserts, top position
        for (int i = 0; i < 4; i++)
            queue_op(KIND_INSERT, draw_value(), draw_position(1'b0), 1'b0);
        queue_op(KIND_SELECT, draw_value(), 8'd255, 1'b0);
        queue_op(KIND_RANK, '1, draw_position(1'b0), 1'b0);

        // mixed operations, mostly well-formed positions, one hold half way
        for (int i = 0; i < 210; i++) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                queue_op(KIND_INSERT, draw_value(), draw_position(1'b0), i == 105);
            else if (r < 40)
                queue_op(KIND_DELETE, draw_value(), draw_position($urandom_range(0, 9) != 0),
                         i == 105);
            else if (r < 60)
                queue_op(KIND_RANK, draw_value(), draw_position(1'b0), i == 105);
            else
                queue_op(KIND_SELECT, draw_value(), draw_position($urandom_range(0, 9) != 0),
                         i == 105);
        end

        // single reset at the start
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every beat to be sent and answered, then a short tail
        while (ops_to_send.size() > 0 || in_valid || answers_due.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (errors == 0) begin
            $display("order_statistic_multiset_core verification clean");
        end else begin
            $display("order_statistic_multiset_core verification failed");
        end
        $finish;
    end

endmodule
